### hw/rtl/siph24_pkg.sv
package siph24_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned STEP_W = 4;
	localparam int unsigned LEN_W  = 8;

	localparam logic [WORD_W-1:0] INIT_A    = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] INIT_B    = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] INIT_C    = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] INIT_D    = 64'h7465646279746573;
	localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;
	localparam int unsigned       LEN_SHIFT = 56;

	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE = 4'd0;
	localparam step_t STEP_ABS0 = 4'd1;
	localparam step_t STEP_ABS1 = 4'd2;
	localparam step_t STEP_TAL0 = 4'd3;
	localparam step_t STEP_TAL1 = 4'd4;
	localparam step_t STEP_FIN0 = 4'd5;
	localparam step_t STEP_FIN1 = 4'd6;
	localparam step_t STEP_FIN2 = 4'd7;
	localparam step_t STEP_FIN3 = 4'd8;

	typedef enum logic [1:0] {
		JMP_SEQ,
		JMP_TAKE,
		JMP_WORD,
		JMP_EMIT
	} jmp_t;

	typedef struct packed {
		logic rnd;
		logic d_blk;
		logic c_ff;
		logic a_blk;
		logic emit;
		jmp_t jmp;
	} ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} lanes_t;

	function automatic ctl_t ctl_word(input step_t step);
		ctl_t w;
		w = '{rnd: 1'b0, d_blk: 1'b0, c_ff: 1'b0, a_blk: 1'b0, emit: 1'b0, jmp: JMP_TAKE};
		unique case (step)
			STEP_IDLE: w.jmp = JMP_TAKE;
			STEP_ABS0: begin w.rnd = 1'b1; w.d_blk = 1'b1; w.jmp = JMP_SEQ; end
			STEP_ABS1: begin w.rnd = 1'b1; w.a_blk = 1'b1; w.jmp = JMP_WORD; end
			STEP_TAL0: begin w.rnd = 1'b1; w.d_blk = 1'b1; w.jmp = JMP_SEQ; end
			STEP_TAL1: begin w.rnd = 1'b1; w.a_blk = 1'b1; w.jmp = JMP_SEQ; end
			STEP_FIN0: begin w.rnd = 1'b1; w.c_ff = 1'b1; w.jmp = JMP_SEQ; end
			STEP_FIN1: begin w.rnd = 1'b1; w.jmp = JMP_SEQ; end
			STEP_FIN2: begin w.rnd = 1'b1; w.jmp = JMP_SEQ; end
			STEP_FIN3: begin w.rnd = 1'b1; w.emit = 1'b1; w.jmp = JMP_EMIT; end
			default:   w.jmp = JMP_TAKE;
		endcase
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic lanes_t sip_round(input lanes_t l);
		lanes_t r;
		r = l;
		r.a = r.a + r.b;
		r.b = rotl(r.b, 13) ^ r.a;
		r.a = rotl(r.a, 32);
		r.c = r.c + r.d;
		r.d = rotl(r.d, 16) ^ r.c;
		r.a = r.a + r.d;
		r.d = rotl(r.d, 21) ^ r.a;
		r.c = r.c + r.b;
		r.b = rotl(r.b, 17) ^ r.c;
		r.c = rotl(r.c, 32);
		return r;
	endfunction

endpackage

### hw/rtl/siphash_2_4_keyed_hash.sv
// SipHash-2-4 engine with a 128-bit key in two registers (index 0 key bytes 0..7, index 1 key
// bytes 8..15). The key is read only when the first word of a message is taken, so a new key
// takes effect at the next message start. Write it while no word is being processed.
// Message words arrive as 64-bit little-endian beats; byte_count matters only on the beat
// marked final_word and saturates at 8. One SipRound unit runs one round per cycle under a
// small microcode table, so a non-final word runs rounds ABS0 and ABS1 and the next word is
// taken in ABS1. A final word with fewer than 8 bytes runs TAL0, TAL1 and FIN0 to FIN3; a full
// final word runs ABS0 and ABS1, then a length-only block through those steps. FIN3 registers
// the hash and the next word is taken in the IDLE step after it. The hash sits in an output
// register while the next message starts; the last round holds until the previous hash is taken.
module siphash_2_4_keyed_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        final_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value
);

	logic [63:0] key_lo_q, key_hi_q;
	siph24_pkg::lanes_t lanes_q, rnd_in, rnd_out;
	logic [63:0] blk_q, hash_q;
	logic [7:0] len_q, len_base, len_new;
	logic open_q, fin_q, out_valid_q;
	siph24_pkg::step_t step_q, step_d;
	siph24_pkg::ctl_t ctl;
	logic accept, stall, advance, short_tail;
	logic [3:0] eff_count;
	logic [63:0] masked, tail_blk;

	assign ctl = siph24_pkg::ctl_word(step_q);

	assign in_ready = (ctl.jmp == siph24_pkg::JMP_TAKE) ||
			((ctl.jmp == siph24_pkg::JMP_WORD) && !fin_q);
	assign accept = in_valid && in_ready;
	assign stall = ctl.emit && out_valid_q && !out_ready;
	assign advance = !stall;

	assign short_tail = final_word && (byte_count < 4'd8);
	assign eff_count = short_tail ? byte_count : 4'd8;
	assign len_base = open_q ? len_q : 8'd0;
	assign len_new = len_base + {4'd0, eff_count};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			masked[i*8 +: 8] = (i < int'(byte_count)) ? data_word[i*8 +: 8] : 8'd0;
		end
		tail_blk = masked | ({56'd0, len_new} << siph24_pkg::LEN_SHIFT);
	end

	always_comb begin
		rnd_in = lanes_q;
		if (ctl.c_ff) begin
			rnd_in.c = lanes_q.c ^ siph24_pkg::FINAL_XOR;
		end
		if (ctl.d_blk) begin
			rnd_in.d = lanes_q.d ^ blk_q;
		end
		rnd_out = siph24_pkg::sip_round(rnd_in);
		if (ctl.a_blk) begin
			rnd_out.a = rnd_out.a ^ blk_q;
		end
	end

	always_comb begin
		step_d = step_q;
		unique case (ctl.jmp)
			siph24_pkg::JMP_SEQ: step_d = step_q + siph24_pkg::step_t'(1);
			siph24_pkg::JMP_TAKE: begin
				if (accept) begin
					step_d = short_tail ? siph24_pkg::STEP_TAL0 : siph24_pkg::STEP_ABS0;
				end
			end
			siph24_pkg::JMP_WORD: begin
				if (fin_q) begin
					step_d = siph24_pkg::STEP_TAL0;
				end else if (accept) begin
					step_d = short_tail ? siph24_pkg::STEP_TAL0 : siph24_pkg::STEP_ABS0;
				end else begin
					step_d = siph24_pkg::STEP_IDLE;
				end
			end
			siph24_pkg::JMP_EMIT: begin
				if (advance) begin
					step_d = siph24_pkg::STEP_IDLE;
				end
			end
			default: step_d = siph24_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= siph24_pkg::STEP_IDLE;
			open_q <= 1'b0;
			len_q <= 8'd0;
			out_valid_q <= 1'b0;
			key_lo_q <= 64'd0;
			key_hi_q <= 64'd0;
			fin_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_we) begin
				if (cfg_index == siph24_pkg::REG_KEY_LOW) begin
					key_lo_q <= cfg_data;
				end else begin
					key_hi_q <= cfg_data;
				end
			end
			if (accept) begin
				open_q <= 1'b1;
				len_q <= len_new;
				fin_q <= final_word;
			end else if (ctl.emit && advance) begin
				open_q <= 1'b0;
				len_q <= 8'd0;
			end
			if (ctl.emit && advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rnd && advance) begin
			lanes_q <= rnd_out;
		end else if (accept && !open_q) begin
			lanes_q.a <= siph24_pkg::INIT_A ^ key_lo_q;
			lanes_q.b <= siph24_pkg::INIT_B ^ key_hi_q;
			lanes_q.c <= siph24_pkg::INIT_C ^ key_lo_q;
			lanes_q.d <= siph24_pkg::INIT_D ^ key_hi_q;
		end
		if (accept) begin
			blk_q <= short_tail ? tail_blk : data_word;
		end else if ((ctl.jmp == siph24_pkg::JMP_WORD) && fin_q) begin
			blk_q <= {56'd0, len_q} << siph24_pkg::LEN_SHIFT;
		end
		if (ctl.emit && advance) begin
			hash_q <= rnd_out.a ^ rnd_out.b ^ rnd_out.c ^ rnd_out.d;
		end
	end

	assign out_valid = out_valid_q;
	assign hash_value = hash_q;

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= siph24_pkg::STEP_FIN3)
		else $error("step counter left the program");

	a_mid_word_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == siph24_pkg::STEP_ABS1 && !fin_q) |=> !$rose(out_valid))
		else $error("result raised after a non-final word");

	a_result_from_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step_q) == siph24_pkg::STEP_FIN3)
		else $error("result raised outside the last round");

	a_close_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (!open_q && len_q == 8'd0))
		else $error("message still open after its result");
`endif

endmodule
